// ----- hw/rtl/mcbg_pkg.sv -----
package mcbg_pkg;

    localparam int CHANNELS = 4;
    localparam int MAX_CH   = 4;

    localparam int CH_W     = 2;
    localparam int CH_CNT_W = 3;
    localparam int CNT_W    = 32;
    localparam int TK_W     = 16;
    localparam int DVD_W    = CNT_W + 1;
    localparam int CFG_IDX_W = $clog2(2 * MAX_CH);

    // Bit 0 of a register index selects the on-time or the cycle length of a channel.
    localparam logic CFG_SEL_ON    = 1'b0;
    localparam logic CFG_SEL_CYCLE = 1'b1;

    localparam logic [MAX_CH-1:0][TK_W-1:0] ON_RESET    = {16'd1, 16'd2, 16'd0, 16'd0};
    localparam logic [MAX_CH-1:0][TK_W-1:0] CYCLE_RESET = {16'd11, 16'd4, 16'd1, 16'd1};
    localparam logic [CNT_W-1:0] LIMIT_CH2_RESET = 32'h0000_FFFF;
    localparam logic [MAX_CH-1:0][CNT_W-1:0] LIMIT_RESET =
        {32'd0, LIMIT_CH2_RESET, 32'd0, 32'd0};

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2
    } func_t;

    typedef struct packed {
        func_t             func;
        logic [CH_W-1:0]   channel;
        logic [CNT_W-1:0]  run_ticks;
    } cmd_word_t;

    typedef struct packed {
        logic [MAX_CH-1:0] on_events;
        logic [MAX_CH-1:0] off_events;
        logic [MAX_CH-1:0] running_mask;
        logic              bad_channel;
    } evt_word_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [TK_W-1:0]   divisor;
    } mod_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TK_W-1:0]   rem;
    } mod_rsp_t;

endpackage

// ----- hw/rtl/mcbg_cfg_regs.sv -----
module mcbg_cfg_regs (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              cfg_we,
    input  logic [mcbg_pkg::CFG_IDX_W-1:0]                    cfg_index,
    input  logic [mcbg_pkg::TK_W-1:0]                         cfg_wdata,
    output logic [mcbg_pkg::MAX_CH-1:0][mcbg_pkg::TK_W-1:0]   on_ticks,
    output logic [mcbg_pkg::MAX_CH-1:0][mcbg_pkg::TK_W-1:0]   cycle_ticks
);
    import mcbg_pkg::*;

    logic [MAX_CH-1:0][TK_W-1:0] on_reg;
    logic [MAX_CH-1:0][TK_W-1:0] on_next;
    logic [MAX_CH-1:0][TK_W-1:0] cycle_reg;
    logic [MAX_CH-1:0][TK_W-1:0] cycle_next;
    logic [CH_W-1:0]             wr_ch;

    assign wr_ch = cfg_index[CFG_IDX_W-1:1];

    always_comb
    begin
        on_next    = on_reg;
        cycle_next = cycle_reg;
        if (cfg_we)
        begin
            if (cfg_index[0] == CFG_SEL_ON)
            begin
                on_next[wr_ch] = cfg_wdata;
            end
            else
            begin
                cycle_next[wr_ch] = cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg    <= ON_RESET;
            cycle_reg <= CYCLE_RESET;
        end
        else
        begin
            on_reg    <= on_next;
            cycle_reg <= cycle_next;
        end
    end

    assign on_ticks    = on_reg;
    assign cycle_ticks = cycle_reg;

endmodule

// ----- hw/rtl/mcbg_mod_unit.sv -----
module mcbg_mod_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  mcbg_pkg::mod_req_t req,
    output mcbg_pkg::mod_rsp_t rsp
);
    import mcbg_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [TK_W-1:0]   rem_reg;
    logic [TK_W-1:0]   rem_next;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  dvd_next;
    logic [TK_W-1:0]   div_reg;
    logic [TK_W-1:0]   div_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [TK_W:0]     trial;
    logic [TK_W:0]     diff;

    // Restoring remainder: one dividend bit enters the partial remainder per cycle.
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            div_next  = req.divisor;
            step_next = STEP_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[TK_W-1:0];
            end
            else
            begin
                rem_next = trial[TK_W-1:0];
            end
            dvd_next  = dvd_reg << 1;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- hw/rtl/multi_channel_blink_generator_unit.sv -----
// Channel  | Handshake                 | Word
// ---------+---------------------------+-------------------------------------
// command  | cmd_valid / cmd_stall     | cmd_data  (func, channel, run_ticks)
// event    | evt_valid / evt_stall     | evt_data  (on, off, running, bad)
// config   | cfg_we                    | cfg_index, cfg_wdata
//
// A start, stop or unused command passes through ST_DONE into the event output register.
// A tick walks every channel in ST_SCAN and, for each running channel, waits in ST_WAIT;
// there the shared remainder unit retires one dividend bit per cycle.
// A new command is accepted once the previous event word sits in the output register.
// Reset zeroes run flags, counts, phases, loads limit and cfg defaults; no clearing pass.
// A stalled event word holds; the command side waits whenever the FSM is not in ST_IDLE.
module multi_channel_blink_generator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  mcbg_pkg::cmd_word_t               cmd_data,
    output logic                              evt_valid,
    input  logic                              evt_stall,
    output mcbg_pkg::evt_word_t               evt_data,
    input  logic                              cfg_we,
    input  logic [mcbg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcbg_pkg::TK_W-1:0]         cfg_wdata
);
    import mcbg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [CH_CNT_W-1:0]          ch_reg;
    logic [CH_CNT_W-1:0]          ch_next;
    logic [MAX_CH-1:0]            running_reg;
    logic [MAX_CH-1:0]            running_next;
    logic [MAX_CH-1:0][CNT_W-1:0] count_reg;
    logic [MAX_CH-1:0][CNT_W-1:0] count_next;
    logic [MAX_CH-1:0][TK_W-1:0]  phase_reg;
    logic [MAX_CH-1:0][TK_W-1:0]  phase_next;
    logic [MAX_CH-1:0][CNT_W-1:0] limit_reg;
    logic [MAX_CH-1:0][CNT_W-1:0] limit_next;
    logic [MAX_CH-1:0]            on_ev_reg;
    logic [MAX_CH-1:0]            on_ev_next;
    logic [MAX_CH-1:0]            off_ev_reg;
    logic [MAX_CH-1:0]            off_ev_next;
    logic                         bad_reg;
    logic                         bad_next;
    logic                         evt_valid_reg;
    logic                         evt_valid_next;
    evt_word_t                    evt_data_reg;
    evt_word_t                    evt_data_next;
    logic [MAX_CH-1:0]            mask;

    logic [MAX_CH-1:0][TK_W-1:0]  on_ticks;
    logic [MAX_CH-1:0][TK_W-1:0]  cycle_ticks;
    mod_req_t                     mod_req;
    mod_rsp_t                     mod_rsp;

    logic [CH_W-1:0]              cur;
    logic [CNT_W-1:0]             new_count;
    logic                         cmd_bad;

    mcbg_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .on_ticks    (on_ticks),
        .cycle_ticks (cycle_ticks)
    );

    mcbg_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    assign cur       = ch_reg[CH_W-1:0];
    assign new_count = count_reg[cur] + CNT_W'(1);
    assign cmd_bad   = CH_CNT_W'(cmd_data.channel) >= CH_CNT_W'(CHANNELS);

    always_comb
    begin
        mask = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            mask[c] = running_reg[c];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        running_next   = running_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        limit_next     = limit_reg;
        on_ev_next     = on_ev_reg;
        off_ev_next    = off_ev_reg;
        bad_next       = bad_reg;
        evt_valid_next = evt_valid_reg;
        evt_data_next  = evt_data_reg;
        mod_req.start    = 1'b0;
        // The phase after this tick is (new_count + 1) mod cycle, the sum kept in 33 bits.
        mod_req.dividend = {1'b0, new_count} + DVD_W'(1);
        mod_req.divisor  = (cycle_ticks[cur] == '0) ? TK_W'(1) : cycle_ticks[cur];

        if (evt_valid_reg && !evt_stall)
        begin
            evt_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    on_ev_next  = '0;
                    off_ev_next = '0;
                    bad_next    = 1'b0;
                    state_next  = ST_DONE;
                    case (cmd_data.func)
                        FUNC_TICK:
                        begin
                            ch_next    = '0;
                            state_next = ST_SCAN;
                        end
                        FUNC_START:
                        begin
                            if (cmd_bad)
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                limit_next[cmd_data.channel]   = cmd_data.run_ticks;
                                running_next[cmd_data.channel] = 1'b1;
                            end
                        end
                        FUNC_STOP:
                        begin
                            if (cmd_bad)
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                running_next[cmd_data.channel] = 1'b0;
                            end
                        end
                        default:
                        begin
                            bad_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (ch_reg == CH_CNT_W'(CHANNELS))
                begin
                    state_next = ST_DONE;
                end
                else if (running_reg[cur])
                begin
                    count_next[cur] = new_count;
                    if (new_count >= limit_reg[cur])
                    begin
                        running_next[cur] = 1'b0;
                    end
                    on_ev_next[cur]  = (phase_reg[cur] == '0);
                    off_ev_next[cur] = (phase_reg[cur] == on_ticks[cur]);
                    mod_req.start    = 1'b1;
                    state_next       = ST_WAIT;
                end
                else
                begin
                    ch_next = ch_reg + CH_CNT_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    phase_next[cur] = mod_rsp.rem;
                    ch_next         = ch_reg + CH_CNT_W'(1);
                    state_next      = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                if (!evt_valid_reg || !evt_stall)
                begin
                    evt_valid_next             = 1'b1;
                    evt_data_next.on_events    = on_ev_reg;
                    evt_data_next.off_events   = off_ev_reg;
                    evt_data_next.running_mask = mask;
                    evt_data_next.bad_channel  = bad_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            running_reg   <= '0;
            count_reg     <= '0;
            phase_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            running_reg   <= running_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            limit_reg     <= limit_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        on_ev_reg    <= on_ev_next;
        off_ev_reg   <= off_ev_next;
        bad_reg      <= bad_next;
        evt_data_reg <= evt_data_next;
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign evt_valid = evt_valid_reg;
    assign evt_data  = evt_data_reg;

`ifndef SYNTHESIS
    a_mod_start_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mod_req.start |-> state_reg == ST_SCAN)
        else $error("remainder unit started outside the channel scan");

    a_evt_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(evt_valid) |-> $past(state_reg == ST_DONE))
        else $error("event word appeared without a finished command");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ch_reg <= CH_CNT_W'(CHANNELS))
        else $error("channel scan ran past the last channel");

    a_wait_has_unit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WAIT |-> mod_rsp.busy || mod_rsp.done)
        else $error("waiting on an idle remainder unit");
`endif

endmodule
